/* rtl/core/aho_corasick_matcher_top_macros.svh */
// assertion macros used by the matcher checker
`ifndef AHO_CORASICK_MATCHER_TOP_MACROS_SVH
`define AHO_CORASICK_MATCHER_TOP_MACROS_SVH

// checked only out of reset
`define ACM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset too
`define ACM_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/acm_pkg.sv */
// shared types and constants of the aho-corasick matcher
`default_nettype none
package acm_pkg;
  localparam int unsigned MAX_NODES = 256;
  localparam int unsigned NODE_W    = $clog2(MAX_NODES);
  localparam int unsigned ALPHA     = 3;
  localparam int unsigned SYM_W     = 2;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned PID_W     = 5;
  localparam int unsigned NUM_PAT   = 2 ** PID_W;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned QDEPTH    = 256;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH) + 1;
  localparam int unsigned ROW_W     = ALPHA * NODE_W;
  localparam int unsigned END_W     = PID_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [ROW_W-1:0]  row_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_END    = 3'd1,
    OP_BUILD  = 3'd2,
    OP_START  = 3'd3,
    OP_SCAN   = 3'd4,
    OP_READ   = 3'd5
  } op_e;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
    logic             status;
  } res_t;

  function automatic node_t kid(input row_t row, input logic [SYM_W-1:0] s);
    node_t n;
    n = '0;
    if (s < SYM_W'(ALPHA)) n = row[s*NODE_W +: NODE_W];
    return n;
  endfunction

  function automatic row_t row_set(input row_t row, input logic [SYM_W-1:0] s,
                                   input node_t n);
    row_t r;
    r = row;
    if (s < SYM_W'(ALPHA)) r[s*NODE_W +: NODE_W] = n;
    return r;
  endfunction
endpackage
`default_nettype wire

/* rtl/core/aho_corasick_matcher_top.sv */
// Aho-Corasick matcher over a three-symbol alphabet, trie held in rams.
// After reset the block clears its node tables before it takes the first
// beat. One item is in work at a time; each gives one result beat, held
// in an output register so the next item can start. Insert and read count
// wait on a ram read; end pattern and start text go straight to the result.
// A scan falls back along failure links until a child on the symbol exists
// or the root is reached, then walks the failure chain of the new node and
// counts each node on it that ends a pattern. A build clears the failure
// table, then walks the trie breadth first, following failure hops to set
// the failure link of each child below the first level. Every step is
// bound by the registered read of the node rams.
`default_nettype none
module aho_corasick_matcher_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [acm_pkg::OP_W-1:0]   opcode_i,
  input  wire logic [acm_pkg::SYM_W-1:0]  symbol_i,
  input  wire logic [acm_pkg::PID_W-1:0]  pattern_id_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [acm_pkg::CNT_W-1:0]       count_o,
  output logic                            status_o
);
  acm_pkg::res_t res;
  logic res_ready;
  logic out_valid_q;
  logic [acm_pkg::CNT_W-1:0] count_q;
  logic status_q;

  assign res_ready = !out_valid_q || out_ready_i;

  acm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .opcode_i, .symbol_i, .pattern_id_i,
    .res_o(res), .res_ready_i(res_ready)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      count_q <= res.count;
      status_q <= res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign count_o = count_q;
  assign status_o = status_q;
endmodule
`default_nettype wire

/* rtl/core/acm_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module acm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

/* rtl/core/acm_ctrl.sv */
// sequencer that walks the trie tables held in rams
`default_nettype none
module acm_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [acm_pkg::OP_W-1:0]   opcode_i,
  input  wire logic [acm_pkg::SYM_W-1:0]  symbol_i,
  input  wire logic [acm_pkg::PID_W-1:0]  pattern_id_i,
  output acm_pkg::res_t                   res_o,
  input  wire logic                       res_ready_i
);
  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_INS    = 14'b00000000000100,
    S_READ   = 14'b00000000001000,
    S_SC_FOL = 14'b00000000010000,
    S_SC_END = 14'b00000000100000,
    S_SC_CNT = 14'b00000001000000,
    S_BCLR   = 14'b00000010000000,
    S_BT     = 14'b00000100000000,
    S_BS     = 14'b00001000000000,
    S_BW     = 14'b00010000000000,
    S_BDQ    = 14'b00100000000000,
    S_BDQW   = 14'b01000000000000,
    S_RESP   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  acm_pkg::node_t cursor_q, cursor_d, match_q, match_d, p_q, p_d, t_q, t_d;
  acm_pkg::node_t ft_q, ft_d, clr_q, clr_d;
  acm_pkg::row_t  row_q, row_d;
  logic [acm_pkg::NODE_W:0]   nodes_q, nodes_d;
  logic [acm_pkg::QPTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [acm_pkg::SYM_W-1:0]  sym_q, sym_d, s_q, s_d;
  logic [acm_pkg::PID_W-1:0]  pid_q, pid_d, id_q, id_d;
  logic [acm_pkg::NUM_PAT-1:0] cvalid_q, cvalid_d;
  logic [acm_pkg::CNT_W-1:0]  res_count_q, res_count_d;
  logic                       res_status_q, res_status_d;

  acm_pkg::node_t node_ra;
  logic child_we, fail_we, end_we, cnt_we, q_we;
  acm_pkg::node_t child_wa, fail_wa, end_wa, fail_wd, q_wd;
  acm_pkg::row_t  child_wd, child_rd;
  acm_pkg::node_t fail_rd, q_rd;
  logic [acm_pkg::END_W-1:0] end_wd, end_rd;
  logic [acm_pkg::PID_W-1:0] cnt_ra, cnt_wa;
  logic [acm_pkg::CNT_W-1:0] cnt_wd, cnt_rd, cnt_cur;
  logic enq, adv_sym;
  acm_pkg::node_t enq_node, c_fol, c_bs, k_bw;

  acm_ram #(.WIDTH(acm_pkg::ROW_W), .DEPTH(acm_pkg::MAX_NODES)) u_child (
    .clk_i, .we_i(child_we), .waddr_i(child_wa), .wdata_i(child_wd),
    .raddr_i(node_ra), .rdata_o(child_rd)
  );
  acm_ram #(.WIDTH(acm_pkg::NODE_W), .DEPTH(acm_pkg::MAX_NODES)) u_fail (
    .clk_i, .we_i(fail_we), .waddr_i(fail_wa), .wdata_i(fail_wd),
    .raddr_i(node_ra), .rdata_o(fail_rd)
  );
  acm_ram #(.WIDTH(acm_pkg::END_W), .DEPTH(acm_pkg::MAX_NODES)) u_end (
    .clk_i, .we_i(end_we), .waddr_i(end_wa), .wdata_i(end_wd),
    .raddr_i(node_ra), .rdata_o(end_rd)
  );
  acm_ram #(.WIDTH(acm_pkg::CNT_W), .DEPTH(acm_pkg::NUM_PAT)) u_cnt (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_wa), .wdata_i(cnt_wd),
    .raddr_i(cnt_ra), .rdata_o(cnt_rd)
  );
  acm_ram #(.WIDTH(acm_pkg::NODE_W), .DEPTH(acm_pkg::QDEPTH)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(tail_q[acm_pkg::QPTR_W-2:0]), .wdata_i(q_wd),
    .raddr_i(head_q[acm_pkg::QPTR_W-2:0]), .rdata_o(q_rd)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign res_o.valid  = (state_q == S_RESP);
  assign res_o.count  = res_count_q;
  assign res_o.status = res_status_q;

  assign c_fol = acm_pkg::kid(child_rd, sym_q);
  assign c_bs  = acm_pkg::kid(row_q, s_q);
  assign k_bw  = acm_pkg::kid(child_rd, s_q);
  assign cnt_cur = cvalid_q[id_q] ? cnt_rd : '0;

  always_comb begin
    state_d = state_q;
    cursor_d = cursor_q; match_d = match_q; p_d = p_q; t_d = t_q;
    ft_d = ft_q; clr_d = clr_q; row_d = row_q; nodes_d = nodes_q;
    head_d = head_q; tail_d = tail_q; sym_d = sym_q; s_d = s_q;
    pid_d = pid_q; id_d = id_q; cvalid_d = cvalid_q;
    res_count_d = res_count_q; res_status_d = res_status_q;
    node_ra = p_q;
    child_we = 1'b0; child_wa = cursor_q; child_wd = '0;
    fail_we = 1'b0; fail_wa = clr_q; fail_wd = '0;
    end_we = 1'b0; end_wa = cursor_q; end_wd = '0;
    cnt_ra = pid_q; cnt_we = 1'b0; cnt_wa = id_q;
    cnt_wd = cnt_cur + acm_pkg::CNT_W'(1);
    enq = 1'b0; enq_node = c_bs; adv_sym = 1'b0;
    q_we = 1'b0; q_wd = enq_node;

    unique case (state_q)
      S_CLEAR: begin
        child_we = 1'b1; child_wa = clr_q;
        fail_we = 1'b1;
        end_we = 1'b1; end_wa = clr_q;
        clr_d = clr_q + acm_pkg::NODE_W'(1);
        if (clr_q == acm_pkg::NODE_W'(acm_pkg::MAX_NODES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          sym_d = symbol_i;
          pid_d = pattern_id_i;
          res_count_d = '0;
          res_status_d = 1'b0;
          state_d = S_RESP;
          case (acm_pkg::op_e'(opcode_i))
            acm_pkg::OP_INSERT: begin
              node_ra = cursor_q;
              if (symbol_i < acm_pkg::SYM_W'(acm_pkg::ALPHA)) state_d = S_INS;
            end
            acm_pkg::OP_END: begin
              end_we = 1'b1;
              end_wd = {1'b1, pattern_id_i};
              cursor_d = '0;
            end
            acm_pkg::OP_BUILD: begin
              clr_d = '0;
              state_d = S_BCLR;
            end
            acm_pkg::OP_START: begin
              cvalid_d = '0;
              match_d = '0;
            end
            acm_pkg::OP_SCAN: begin
              if (symbol_i < acm_pkg::SYM_W'(acm_pkg::ALPHA)) begin
                node_ra = match_q;
                p_d = match_q;
                state_d = S_SC_FOL;
              end else begin
                match_d = '0;
              end
            end
            acm_pkg::OP_READ: begin
              cnt_ra = pattern_id_i;
              state_d = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        state_d = S_RESP;
        if (c_fol != '0) begin
          cursor_d = c_fol;
        end else if (nodes_q >= (acm_pkg::NODE_W+1)'(acm_pkg::MAX_NODES)) begin
          res_status_d = 1'b1;
        end else begin
          child_we = 1'b1;
          child_wd = acm_pkg::row_set(child_rd, sym_q, nodes_q[acm_pkg::NODE_W-1:0]);
          cursor_d = nodes_q[acm_pkg::NODE_W-1:0];
          nodes_d = nodes_q + (acm_pkg::NODE_W+1)'(1);
        end
      end
      S_READ: begin
        res_count_d = cvalid_q[pid_q] ? cnt_rd : '0;
        state_d = S_RESP;
      end
      S_SC_FOL: begin
        // fall back along failure links until a child on the symbol exists or the root is reached
        if (p_q != '0 && c_fol == '0) begin
          p_d = fail_rd;
          node_ra = fail_rd;
        end else begin
          match_d = c_fol;
          p_d = c_fol;
          node_ra = c_fol;
          state_d = (c_fol == '0) ? S_RESP : S_SC_END;
        end
      end
      S_SC_END: begin
        p_d = fail_rd;
        if (end_rd[acm_pkg::END_W-1]) begin
          cnt_ra = end_rd[acm_pkg::PID_W-1:0];
          id_d = end_rd[acm_pkg::PID_W-1:0];
          state_d = S_SC_CNT;
        end else if (fail_rd == '0) begin
          state_d = S_RESP;
        end else begin
          node_ra = fail_rd;
        end
      end
      S_SC_CNT: begin
        if (cnt_cur != acm_pkg::CNT_MAX) begin
          cnt_we = 1'b1;
          cvalid_d[id_q] = 1'b1;
        end
        if (p_q == '0) begin
          state_d = S_RESP;
        end else begin
          node_ra = p_q;
          state_d = S_SC_END;
        end
      end
      S_BCLR: begin
        fail_we = 1'b1;
        clr_d = clr_q + acm_pkg::NODE_W'(1);
        if (clr_q == acm_pkg::NODE_W'(acm_pkg::MAX_NODES - 1)) begin
          t_d = '0;
          node_ra = '0;
          head_d = '0;
          tail_d = '0;
          state_d = S_BT;
        end
      end
      S_BT: begin
        row_d = child_rd;
        ft_d = fail_rd;
        s_d = '0;
        state_d = S_BS;
      end
      S_BS: begin
        if (c_bs == '0) begin
          adv_sym = 1'b1;
        end else if (t_q == '0) begin
          // children of the root keep the root as failure link
          enq = 1'b1;
          adv_sym = 1'b1;
        end else begin
          p_d = ft_q;
          node_ra = ft_q;
          state_d = S_BW;
        end
      end
      S_BW: begin
        if (k_bw != '0 || p_q == '0) begin
          fail_we = 1'b1;
          fail_wa = c_bs;
          fail_wd = k_bw;
          enq = 1'b1;
          adv_sym = 1'b1;
          state_d = S_BS;
        end else begin
          p_d = fail_rd;
          node_ra = fail_rd;
        end
      end
      S_BDQ: begin
        if (head_q < tail_q) begin
          head_d = head_q + acm_pkg::QPTR_W'(1);
          state_d = S_BDQW;
        end else begin
          state_d = S_RESP;
        end
      end
      S_BDQW: begin
        t_d = q_rd;
        node_ra = q_rd;
        state_d = S_BT;
      end
      S_RESP: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase

    if (enq && tail_q < acm_pkg::QPTR_W'(acm_pkg::QDEPTH)) begin
      q_we = 1'b1;
      tail_d = tail_q + acm_pkg::QPTR_W'(1);
    end
    if (adv_sym) begin
      if (s_q == acm_pkg::SYM_W'(acm_pkg::ALPHA - 1)) state_d = S_BDQ;
      else s_d = s_q + acm_pkg::SYM_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cursor_q <= '0; match_q <= '0; p_q <= '0; t_q <= '0; ft_q <= '0;
      clr_q <= '0; nodes_q <= (acm_pkg::NODE_W+1)'(1);
      head_q <= '0; tail_q <= '0; s_q <= '0; cvalid_q <= '0;
    end else begin
      state_q <= state_d;
      cursor_q <= cursor_d; match_q <= match_d; p_q <= p_d; t_q <= t_d;
      ft_q <= ft_d; clr_q <= clr_d; nodes_q <= nodes_d;
      head_q <= head_d; tail_q <= tail_d; s_q <= s_d; cvalid_q <= cvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    sym_q <= sym_d;
    pid_q <= pid_d;
    id_q <= id_d;
    res_count_q <= res_count_d;
    res_status_q <= res_status_d;
  end
endmodule
`default_nettype wire

/* rtl/core/acm_checker.sv */
// port-level checks of the matcher, bound to the top level
`default_nettype none
`include "aho_corasick_matcher_top_macros.svh"
module acm_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [acm_pkg::CNT_W-1:0] count_o,
  input wire logic                      status_o
);
  `ACM_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(count_o) && $stable(status_o), "result beat changed while stalled")
  `ACM_ASSERT(a_full_no_count, out_valid_o && status_o |-> count_o == '0, "full flag with a nonzero count")
  `ACM_ASSERT_RST(a_clear_busy, !rst_ni |=> !in_ready_o, "ready during table clear")
  `ACM_ASSERT(a_one_item, in_valid_i && in_ready_o |=> !in_ready_o, "second beat taken while busy")
endmodule

bind aho_corasick_matcher_top acm_checker u_acm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .count_o(count_o), .status_o(status_o)
);
`default_nettype wire
